// ----- hw/rtl/aet_pkg.sv -----
// Shared types and codes for the active edge table.
// Depends on nothing; aet_cmp, the top and the bench import it.
package aet_pkg;

	// One edge record, Q16.16 signed fields, front field in the top bits.
	typedef struct packed {
		logic signed [31:0] ymax;
		logic signed [31:0] xmin;
		logic signed [31:0] inv_slope;
		logic signed [31:0] dx;
		logic signed [31:0] dy;
	} edge_rec_t;

	localparam int RecWidth = $bits(edge_rec_t);

	// Request opcodes.
	localparam logic [1:0] OP_ADD   = 2'd0;
	localparam logic [1:0] OP_SORT  = 2'd1;
	localparam logic [1:0] OP_PURGE = 2'd2;
	localparam logic [1:0] OP_READ  = 2'd3;

	// Result status codes.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	// Operand selection of the shared comparator.
	typedef enum logic {
		CMP_PURGE,
		CMP_SORT
	} cmp_sel_t;

endpackage

// ----- hw/rtl/aet_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module aet_ram #(
	parameter int WIDTH = 160,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- hw/rtl/aet_cmp.sv -----
// Shared signed comparator of the active edge table: purge and sort tests.
// Depends on aet_pkg for the record type and operand select codes.
module aet_cmp (
	input  aet_pkg::cmp_sel_t  sel,
	input  aet_pkg::edge_rec_t rec,
	input  logic signed [31:0] key,
	input  logic signed [31:0] limit,
	output logic               gt
);
	import aet_pkg::*;

	logic signed [31:0] lhs;
	logic signed [31:0] rhs;

	// Purge keeps a record whose ymax is above the scanline limit.
	// Sort shifts a record whose xmin is below the held key.
	always_comb begin
		unique case (sel)
			CMP_PURGE: begin
				lhs = rec.ymax;
				rhs = limit;
			end
			CMP_SORT: begin
				lhs = key;
				rhs = rec.xmin;
			end
			default: begin
				lhs = rec.ymax;
				rhs = limit;
			end
		endcase
	end

	assign gt = lhs > rhs;

endmodule

// ----- hw/rtl/active_edge_table_top.sv -----
// Active edge table: add, sort, purge and read requests on a record RAM.
// An add completes in the idle state, a read passes through S_READ, a purge streams
// the entries once, and a sort is an insertion sort; each sort compare costs one RAM read.
// Throughput: busy stays high until done; add never raises busy, so adds go
// back to back. done is a one-cycle strobe and the receiver cannot stall it.
// Reset: arst_n clears the entry count and control; RAM contents stay undefined.
// Depends on aet_pkg, aet_ram and aet_cmp.
module active_edge_table_top #(
	parameter int TABLE_DEPTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [1:0]         op,
	input  logic signed [31:0] edge_ymax,
	input  logic signed [31:0] edge_xmin,
	input  logic signed [31:0] edge_inv_slope,
	input  logic signed [31:0] edge_dx,
	input  logic signed [31:0] edge_dy,
	input  logic signed [15:0] scanline,
	input  logic [4:0]         read_index,
	output logic               busy,
	output logic               done,
	output logic signed [31:0] out_ymax,
	output logic signed [31:0] out_xmin,
	output logic signed [31:0] out_inv_slope,
	output logic signed [31:0] out_dx,
	output logic signed [31:0] out_dy,
	output logic [5:0]         entry_count,
	output logic [1:0]         status
);
	import aet_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int IW = (CW > 5) ? CW : 5;

	// Sequencer states.
	localparam logic [2:0] S_IDLE  = 3'd0; // take requests, finish adds at once
	localparam logic [2:0] S_READ  = 3'd1; // RAM data for a read request arrives
	localparam logic [2:0] S_PURGE = 3'd2; // stream entries, compact survivors
	localparam logic [2:0] S_LOAD  = 3'd3; // sort: capture the entry being inserted
	localparam logic [2:0] S_SCAN  = 3'd4; // sort: compare and shift one neighbor
	localparam logic [2:0] S_PLACE = 3'd5; // sort: drop held entry at address zero

	// The table is stored back to front: logical position k lives at address
	// count-1-k. An add is then a single write at address count, a stable
	// ascending sort by position becomes a stable descending sort by address,
	// and purge compaction keeps order in either direction.

	logic [2:0]         state_q, state_d;
	logic [CW-1:0]      count_q, count_d;
	logic [CW-1:0]      ptr_q, ptr_d;   // purge read pointer, sort outer index
	logic [CW-1:0]      pos_q, pos_d;   // purge write pointer, sort hole position
	edge_rec_t          tmp_q;          // sort: entry being inserted
	logic signed [31:0] limit_q;        // purge: scanline in Q16.16

	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	edge_rec_t          ram_wdata;
	logic [AW-1:0]      ram_raddr;
	edge_rec_t          ram_rdata;

	cmp_sel_t           cmp_sel;
	logic               cmp_gt;

	logic               accept;
	logic               fin;
	logic [1:0]         fin_status;
	logic               fin_rec;
	logic               tmp_load;
	logic [CW-1:0]      next_i;
	logic [CW-1:0]      ptr_m1;
	logic [CW-1:0]      pos_m2;
	logic [IW-1:0]      idx_w;
	logic [IW-1:0]      cnt_w;
	logic [IW-1:0]      phys_w;
	logic               idx_bad;
	edge_rec_t          in_rec;

	logic               done_q;
	logic [1:0]         status_q;
	logic [5:0]         entry_count_q;
	edge_rec_t          out_rec_q;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	assign in_rec.ymax      = edge_ymax;
	assign in_rec.xmin      = edge_xmin;
	assign in_rec.inv_slope = edge_inv_slope;
	assign in_rec.dx        = edge_dx;
	assign in_rec.dy        = edge_dy;

	// Read index maps to an address counted down from the last written one.
	assign idx_w   = IW'(read_index);
	assign cnt_w   = IW'(count_q);
	assign idx_bad = (idx_w >= cnt_w);
	assign phys_w  = cnt_w - idx_w - IW'(1);

	assign next_i = ptr_q + CW'(1);
	assign ptr_m1 = ptr_q - CW'(1);
	assign pos_m2 = pos_q - CW'(2);

	aet_ram #(
		.WIDTH (RecWidth),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	aet_cmp u_cmp (
		.sel   (cmp_sel),
		.rec   (ram_rdata),
		.key   (tmp_q.xmin),
		.limit (limit_q),
		.gt    (cmp_gt)
	);

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		ptr_d      = ptr_q;
		pos_d      = pos_q;
		ram_we     = 1'b0;
		ram_waddr  = '0;
		ram_wdata  = ram_rdata;
		ram_raddr  = '0;
		cmp_sel    = CMP_SORT;
		fin        = 1'b0;
		fin_status = ST_OK;
		fin_rec    = 1'b0;
		tmp_load   = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					unique case (op)
						OP_ADD: begin
							fin = 1'b1;
							if (count_q == CW'(TABLE_DEPTH)) begin
								// Drop the add, flag full.
								fin_status = ST_FULL;
							end else begin
								ram_we    = 1'b1;
								ram_waddr = count_q[AW-1:0];
								ram_wdata = in_rec;
								count_d   = count_q + CW'(1);
							end
						end
						OP_SORT: begin
							if (count_q < CW'(2)) begin
								fin = 1'b1;
							end else begin
								ram_raddr = AW'(1);
								ptr_d     = CW'(1);
								state_d   = S_LOAD;
							end
						end
						OP_PURGE: begin
							if (count_q == '0) begin
								fin = 1'b1;
							end else begin
								ram_raddr = '0;
								ptr_d     = CW'(1);
								pos_d     = '0;
								state_d   = S_PURGE;
							end
						end
						OP_READ: begin
							if (idx_bad) begin
								fin        = 1'b1;
								fin_status = ST_RANGE;
							end else begin
								ram_raddr = phys_w[AW-1:0];
								state_d   = S_READ;
							end
						end
						default: begin
							fin = 1'b1;
						end
					endcase
				end
			end
			S_READ: begin
				fin     = 1'b1;
				fin_rec = 1'b1;
				state_d = S_IDLE;
			end
			S_PURGE: begin
				// Data for address ptr-1 is on the RAM output; keep it if above limit.
				cmp_sel = CMP_PURGE;
				if (cmp_gt) begin
					ram_we    = 1'b1;
					ram_waddr = pos_q[AW-1:0];
					ram_wdata = ram_rdata;
					pos_d     = pos_q + CW'(1);
				end
				if (ptr_q == count_q) begin
					fin     = 1'b1;
					count_d = cmp_gt ? (pos_q + CW'(1)) : pos_q;
					state_d = S_IDLE;
				end else begin
					ram_raddr = ptr_q[AW-1:0];
					ptr_d     = next_i;
				end
			end
			S_LOAD: begin
				// Hold the entry at address ptr and open a hole there.
				tmp_load  = 1'b1;
				pos_d     = ptr_q;
				ram_raddr = ptr_m1[AW-1:0];
				state_d   = S_SCAN;
			end
			S_SCAN: begin
				ram_we    = 1'b1;
				ram_waddr = pos_q[AW-1:0];
				if (cmp_gt) begin
					// Neighbor below the hole moves up; hole moves down.
					ram_wdata = ram_rdata;
					pos_d     = pos_q - CW'(1);
					if (pos_q == CW'(1)) begin
						state_d = S_PLACE;
					end else begin
						ram_raddr = pos_m2[AW-1:0];
					end
				end else begin
					ram_wdata = tmp_q;
					if (next_i == count_q) begin
						fin     = 1'b1;
						state_d = S_IDLE;
					end else begin
						ram_raddr = next_i[AW-1:0];
						ptr_d     = next_i;
						state_d   = S_LOAD;
					end
				end
			end
			S_PLACE: begin
				ram_we    = 1'b1;
				ram_waddr = '0;
				ram_wdata = tmp_q;
				if (next_i == count_q) begin
					fin     = 1'b1;
					state_d = S_IDLE;
				end else begin
					ram_raddr = next_i[AW-1:0];
					ptr_d     = next_i;
					state_d   = S_LOAD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			ptr_q   <= '0;
			pos_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			ptr_q   <= ptr_d;
			pos_q   <= pos_d;
			done_q  <= fin;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			limit_q <= {scanline, 16'h0000};
		end
		if (tmp_load) begin
			tmp_q <= ram_rdata;
		end
		if (fin) begin
			status_q      <= fin_status;
			entry_count_q <= 6'(count_d);
			out_rec_q     <= fin_rec ? ram_rdata : '0;
		end
	end

	assign done          = done_q;
	assign status        = status_q;
	assign entry_count   = entry_count_q;
	assign out_ymax      = out_rec_q.ymax;
	assign out_xmin      = out_rec_q.xmin;
	assign out_inv_slope = out_rec_q.inv_slope;
	assign out_dx        = out_rec_q.dx;
	assign out_dy        = out_rec_q.dy;

	// Count never passes the table size.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH))
		else $error("entry count above table depth");

	// Leaving a multi-cycle request always produces its result.
	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

	// A full flag only ever reports a full table.
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_FULL) |-> (count_q == CW'(TABLE_DEPTH)))
		else $error("full status with room left");

	// Failed requests carry no record.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |-> (out_ymax == 0 && out_xmin == 0 &&
		out_inv_slope == 0 && out_dx == 0 && out_dy == 0))
		else $error("record data on a failed request");

	// A result follows either an accepted request or busy work.
	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start || busy))
		else $error("result without a request");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for active_edge_table_top: directed corner requests, then random
// add/sort/purge/read phases, each result checked against a table model kept in the bench.
// Depends on aet_pkg and the active_edge_table_top RTL.
module tb;
	import aet_pkg::*;

	localparam int Depth       = 32;
	localparam int NumRandom   = 1200;
	localparam int IdleLimit   = 4000;  // longer than the longest sort
	localparam int DrainCycles = 40;
	localparam int MaxReports  = 10;

	// One request as the driver puts it on the ports.
	typedef struct {
		logic [1:0]         op;
		edge_rec_t          rec;
		logic signed [15:0] line;
		logic [4:0]         index;
	} edge_request_t;

	// One result as the block should report it on done.
	typedef struct {
		edge_rec_t  rec;
		logic [5:0] count;
		logic [1:0] status;
	} table_result_t;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic [1:0]         op = OP_READ;
	logic signed [31:0] edge_ymax = '0;
	logic signed [31:0] edge_xmin = '0;
	logic signed [31:0] edge_inv_slope = '0;
	logic signed [31:0] edge_dx = '0;
	logic signed [31:0] edge_dy = '0;
	logic signed [15:0] scanline = '0;
	logic [4:0]         read_index = '0;
	logic               busy;
	logic               done;
	logic signed [31:0] out_ymax;
	logic signed [31:0] out_xmin;
	logic signed [31:0] out_inv_slope;
	logic signed [31:0] out_dx;
	logic signed [31:0] out_dy;
	logic [5:0]         entry_count;
	logic [1:0]         status;

	// Bench state: requests still to send, the modeled edge table, results owed.
	edge_request_t pending_q[$];
	edge_rec_t     edge_table_q[$];
	table_result_t owed_q[$];

	logic req_fire = 1'b0;   // request on the ports was taken at the last rising edge
	int   idle_cycles = 0;
	int   fail_count = 0;
	int   gap_left = 0;
	int   burst_left = 1;
	bit   timed_out;

	active_edge_table_top #(
		.TABLE_DEPTH(Depth)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.op            (op),
		.edge_ymax     (edge_ymax),
		.edge_xmin     (edge_xmin),
		.edge_inv_slope(edge_inv_slope),
		.edge_dx       (edge_dx),
		.edge_dy       (edge_dy),
		.scanline      (scanline),
		.read_index    (read_index),
		.busy          (busy),
		.done          (done),
		.out_ymax      (out_ymax),
		.out_xmin      (out_xmin),
		.out_inv_slope (out_inv_slope),
		.out_dx        (out_dx),
		.out_dy        (out_dy),
		.entry_count   (entry_count),
		.status        (status)
	);

	// 12 ns clock, high half first after the initial low phase.
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// ---------------------------------------------------------------- stimulus helpers

	// Random 32-bit word, biased toward the signed extremes and the all-zero/all-one words.
	function automatic logic [31:0] random_word();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	// Q16.16 value on or one LSB either side of a small integer line, to hit the purge edge.
	function automatic logic [31:0] near_line();
		int whole;
		int offset;
		whole  = int'($urandom_range(0, 40)) - 20;
		offset = int'($urandom_range(0, 2)) - 1;
		return (whole <<< 16) + offset;
	endfunction

	// Request of the given op with every field filled with noise.
	function automatic edge_request_t noise_request(input logic [1:0] code);
		edge_request_t r;
		r.op            = code;
		r.rec.ymax      = $urandom;
		r.rec.xmin      = $urandom;
		r.rec.inv_slope = $urandom;
		r.rec.dx        = $urandom;
		r.rec.dy        = $urandom;
		r.line          = 16'($urandom);
		r.index         = 5'($urandom_range(0, 31));
		return r;
	endfunction

	function automatic edge_request_t add_request(input logic [31:0] y, input logic [31:0] x,
			input logic [31:0] s, input logic [31:0] ex, input logic [31:0] ey);
		edge_request_t r;
		r               = noise_request(OP_ADD);
		r.rec.ymax      = y;
		r.rec.xmin      = x;
		r.rec.inv_slope = s;
		r.rec.dx        = ex;
		r.rec.dy        = ey;
		return r;
	endfunction

	function automatic edge_request_t table_request(input logic [1:0] code,
			input logic [15:0] line, input logic [4:0] index);
		edge_request_t r;
		r       = noise_request(code);
		r.line  = line;
		r.index = index;
		return r;
	endfunction

	// Add with content shaped for purge boundaries and sort ties.
	function automatic edge_request_t random_add();
		logic [31:0] y;
		logic [31:0] x;
		int          pick;
		y    = ($urandom_range(0, 9) < 7) ? near_line() : random_word();
		pick = $urandom_range(0, 9);
		if (pick < 5)
			x = (int'($urandom_range(0, 15)) - 8) <<< 16;  // few distinct keys: many ties
		else if (pick < 8)
			x = near_line();
		else
			x = random_word();
		return add_request(y, x, random_word(), random_word(), random_word());
	endfunction

	// Purge mostly at small lines where stored ymax values cluster; sometimes anywhere.
	function automatic edge_request_t random_purge();
		logic [15:0] line;
		if ($urandom_range(0, 9) == 0)
			line = 16'($urandom);
		else
			line = 16'(int'($urandom_range(0, 40)) - 20);
		return table_request(OP_PURGE, line, 5'($urandom_range(0, 31)));
	endfunction

	function automatic edge_request_t random_read();
		return table_request(OP_READ, 16'($urandom), 5'($urandom_range(0, 31)));
	endfunction

	// ---------------------------------------------------------------- predictor

	// Apply one accepted request to the modeled table and queue the result it owes.
	task automatic apply_table_request(input edge_request_t r);
		table_result_t res;
		edge_rec_t     held;
		edge_rec_t     survivors[$];
		longint        limit;
		longint        y;
		int            i;
		int            j;
		res.rec    = '0;
		res.status = ST_OK;
		case (r.op)
			OP_ADD: begin
				// drop the record when the table is full
				if (edge_table_q.size() >= Depth)
					res.status = ST_FULL;
				else
					edge_table_q.push_front(r.rec);
			end
			OP_SORT: begin
				// stable insertion sort on signed xmin
				for (i = 1; i < edge_table_q.size(); i++) begin
					held = edge_table_q[i];
					j    = i;
					while (j > 0 && $signed(held.xmin) < $signed(edge_table_q[j - 1].xmin)) begin
						edge_table_q[j] = edge_table_q[j - 1];
						j--;
					end
					edge_table_q[j] = held;
				end
			end
			OP_PURGE: begin
				// keep records strictly above the line, in their current order
				limit = r.line;
				limit = limit * 65536;
				for (i = 0; i < edge_table_q.size(); i++) begin
					y = $signed(edge_table_q[i].ymax);
					if (y > limit)
						survivors.push_back(edge_table_q[i]);
				end
				edge_table_q = survivors;
			end
			default: begin
				if (r.index >= edge_table_q.size())
					res.status = ST_RANGE;
				else
					res.rec = edge_table_q[r.index];
			end
		endcase
		res.count = 6'(edge_table_q.size());
		owed_q.push_back(res);
	endtask

	// ---------------------------------------------------------------- checking

	function automatic string show_result(input table_result_t r);
		return $sformatf("ymax=%h xmin=%h inv_slope=%h dx=%h dy=%h count=%0d status=%0d",
			r.rec.ymax, r.rec.xmin, r.rec.inv_slope, r.rec.dx, r.rec.dy, r.count, r.status);
	endfunction

	task automatic report_failure(input string msg);
		fail_count++;
		if (fail_count <= MaxReports)
			$display("ERROR at %0t ns: %s", $realtime, msg);
	endtask

	// Sample at the rising edge: check results first, then record any request taken.
	always @(posedge clk) begin : monitor
		table_result_t want;
		table_result_t got;
		edge_request_t taken;
		if (!arst_n) begin
			req_fire    <= 1'b0;
			idle_cycles <= 0;
		end else begin
			if (done) begin
				got.rec.ymax      = out_ymax;
				got.rec.xmin      = out_xmin;
				got.rec.inv_slope = out_inv_slope;
				got.rec.dx        = out_dx;
				got.rec.dy        = out_dy;
				got.count         = entry_count;
				got.status        = status;
				if (owed_q.size() == 0) begin
					report_failure({"result with none owed: ", show_result(got)});
				end else begin
					want = owed_q.pop_front();
					if (got.rec.ymax !== want.rec.ymax || got.rec.xmin !== want.rec.xmin ||
							got.rec.inv_slope !== want.rec.inv_slope ||
							got.rec.dx !== want.rec.dx || got.rec.dy !== want.rec.dy ||
							got.count !== want.count || got.status !== want.status)
						report_failure({"mismatch\n  expected ", show_result(want),
							"\n  actual   ", show_result(got)});
				end
			end
			if (start && !busy) begin
				// rebuild the request from the ports so the drive itself is checked too
				taken.op            = op;
				taken.rec.ymax      = edge_ymax;
				taken.rec.xmin      = edge_xmin;
				taken.rec.inv_slope = edge_inv_slope;
				taken.rec.dx        = edge_dx;
				taken.rec.dy        = edge_dy;
				taken.line          = scanline;
				taken.index         = read_index;
				apply_table_request(taken);
			end
			req_fire    <= start && !busy;
			idle_cycles <= (done || (start && !busy)) ? 0 : idle_cycles + 1;
		end
	end

	// ---------------------------------------------------------------- driver

	// Change inputs at the falling edge. Hold a request until it is taken, then
	// advance to the next one or drop start for a gap between bursts.
	always @(negedge clk) begin : driver
		edge_request_t nxt;
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!start || req_fire) begin
			if (gap_left > 0) begin
				start    <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_q.size() > 0) begin
				nxt            = pending_q.pop_front();
				start          <= 1'b1;
				op             <= nxt.op;
				edge_ymax      <= nxt.rec.ymax;
				edge_xmin      <= nxt.rec.xmin;
				edge_inv_slope <= nxt.rec.inv_slope;
				edge_dx        <= nxt.rec.dx;
				edge_dy        <= nxt.rec.dy;
				scanline       <= nxt.line;
				read_index     <= nxt.index;
				if (burst_left <= 1) begin
					// end of burst: pick the next burst length and the gap before it
					burst_left <= $urandom_range(1, 30);
					gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin : sequencer
		int total;
		int n;
		int k;

		// Directed part: empty-table ops, single-entry sort, extremes, ties, purge edges.
		pending_q.push_back(table_request(OP_READ, 16'h0000, 5'd0));    // empty: out of range
		pending_q.push_back(table_request(OP_READ, 16'hffff, 5'd31));
		pending_q.push_back(table_request(OP_SORT, 16'h0000, 5'd0));    // empty sort
		pending_q.push_back(table_request(OP_PURGE, 16'h8000, 5'd0));   // empty purge, min line
		pending_q.push_back(add_request(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
			32'h8000_0000, 32'hffff_ffff));
		pending_q.push_back(table_request(OP_SORT, 16'h0000, 5'd0));    // single entry
		pending_q.push_back(table_request(OP_READ, 16'h0000, 5'd0));
		// ymax exactly on line 32767
		pending_q.push_back(add_request(32'h7fff_0000, 32'h7fff_ffff, 32'h8000_0000,
			32'h7fff_ffff, 32'h0000_0000));
		pending_q.push_back(add_request(32'h8000_0000, 32'h0001_0000, 32'h5555_5555,
			32'haaaa_aaaa, 32'h5555_5555));
		// ymax exactly on line 1, xmin tied with the previous add
		pending_q.push_back(add_request(32'h0001_0000, 32'h0001_0000, 32'haaaa_aaaa,
			32'h5555_5555, 32'haaaa_aaaa));
		// xmin tied with the first add at the most negative key
		pending_q.push_back(add_request(32'h0001_0001, 32'h8000_0000, 32'h0000_0001,
			32'hffff_fffe, 32'h8000_0001));
		pending_q.push_back(table_request(OP_SORT, 16'h0000, 5'd0));
		for (k = 0; k < 6; k++)
			pending_q.push_back(table_request(OP_READ, 16'h0000, 5'(k)));
		pending_q.push_back(table_request(OP_PURGE, 16'h0001, 5'd0));
		pending_q.push_back(table_request(OP_PURGE, 16'h8000, 5'd0));
		pending_q.push_back(table_request(OP_PURGE, 16'h7fff, 5'd31));
		pending_q.push_back(table_request(OP_READ, 16'h0000, 5'd0));
		pending_q.push_back(table_request(OP_READ, 16'h0000, 5'd1));

		// Random part in phases: fill runs (often to full), sort/read/purge sweeps, noise.
		total = pending_q.size() + NumRandom;
		while (pending_q.size() < total) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					n = $urandom_range(5, 45);
					for (k = 0; k < n; k++)
						pending_q.push_back(($urandom_range(0, 5) == 0) ? random_read()
							: random_add());
				end
				4, 5, 6, 7: begin
					if ($urandom_range(0, 4) != 0)
						pending_q.push_back(table_request(OP_SORT, 16'($urandom),
							5'($urandom)));
					n = $urandom_range(1, 6);
					for (k = 0; k < n; k++)
						pending_q.push_back(random_read());
					pending_q.push_back(random_purge());
					n = $urandom_range(0, 4);
					for (k = 0; k < n; k++)
						pending_q.push_back(random_read());
				end
				default: begin
					n = $urandom_range(1, 10);
					for (k = 0; k < n; k++)
						pending_q.push_back(noise_request(2'($urandom_range(0, 3))));
				end
			endcase
		end

		// Reset once, then let the driver run.
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait for every request to be taken and every result to come back.
		timed_out = 1'b0;
		while (!timed_out && (pending_q.size() != 0 || start || owed_q.size() != 0)) begin
			@(posedge clk);
			if (idle_cycles >= IdleLimit)
				timed_out = 1'b1;
		end

		if (timed_out)
			report_failure($sformatf("no request or result for %0d cycles", IdleLimit));
		else
			repeat (DrainCycles) @(posedge clk);
		if (owed_q.size() != 0)
			report_failure($sformatf("%0d results never arrived", owed_q.size()));

		if (fail_count == 0)
			$display("active_edge_table_top test passed");
		else
			$display("active_edge_table_top test failed");
		$finish;
	end

endmodule
